### rtl/bps_pkg.sv
package bps_pkg;

  localparam int NUM_PATTERNS = 12;
  localparam int MAX_STEPS    = 32;
  localparam int ROM_ROWS     = 12;
  localparam int ROW_LEN      = 24;

  localparam int MODE_W  = 2;
  localparam int PAT_W   = 4;
  localparam int POS_W   = 5;
  localparam int ENTRY_W = 8;
  localparam int UNIT_W  = 4;
  localparam int REM_W   = 12;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [ENTRY_W-1:0] STOP_MARK = 8'hFF;
  localparam logic [UNIT_W-1:0]  UNIT_MS_RESET = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE  = 1'b0,
    CFG_UNIT_MS = 1'b1
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_PLAY    = 2'd1,
    MODE_SILENCE = 2'd2
  } mode_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PAT_W-1:0]  pattern;
  } in_t;

  typedef struct packed {
    logic buzzer_on;
    logic busy_res;
    logic done_res;
  } out_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

### rtl/bps_rom.sv
module bps_rom (
  input  logic [bps_pkg::PAT_W-1:0]   pat_i,
  input  logic [bps_pkg::POS_W-1:0]   pos_i,
  output logic [bps_pkg::ENTRY_W-1:0] entry_o
);
  import bps_pkg::*;

  logic [ENTRY_W-1:0] row_val;

  // pattern table, unused tail of each row reads zero
  always_comb begin
    row_val = '0;
    case (pat_i)
      4'd0: begin
        case (pos_i)
          5'd0: row_val = 8'd18;
          5'd1: row_val = 8'd8;
          5'd2: row_val = 8'd18;
          5'd3: row_val = 8'd8;
          5'd4: row_val = 8'd18;
          5'd5: row_val = 8'd8;
          5'd6: row_val = STOP_MARK;
          default: row_val = '0;
        endcase
      end
      4'd1: begin
        case (pos_i)
          5'd0: row_val = 8'd15;
          5'd1: row_val = 8'd5;
          5'd2: row_val = 8'd15;
          5'd3: row_val = 8'd5;
          5'd4: row_val = STOP_MARK;
          default: row_val = '0;
        endcase
      end
      4'd2: begin
        case (pos_i)
          5'd0: row_val = 8'd50;
          5'd1: row_val = 8'd2;
          5'd2: row_val = STOP_MARK;
          default: row_val = '0;
        endcase
      end
      4'd3, 4'd9: begin
        case (pos_i)
          5'd0: row_val = 8'd5;
          5'd1: row_val = 8'd5;
          5'd2: row_val = 8'd5;
          5'd3: row_val = 8'd5;
          5'd4: row_val = STOP_MARK;
          default: row_val = '0;
        endcase
      end
      4'd4: begin
        case (pos_i)
          5'd0: row_val = 8'd20;
          5'd1: row_val = 8'd15;
          5'd2: row_val = 8'd35;
          5'd3: row_val = 8'd5;
          5'd4: row_val = STOP_MARK;
          default: row_val = '0;
        endcase
      end
      4'd5, 4'd8: begin
        case (pos_i)
          5'd0: row_val = 8'd245;
          5'd1: row_val = STOP_MARK;
          default: row_val = '0;
        endcase
      end
      4'd6: begin
        case (pos_i)
          5'd0:  row_val = 8'd19;
          5'd1:  row_val = 8'd5;
          5'd2:  row_val = 8'd9;
          5'd3:  row_val = 8'd5;
          5'd4:  row_val = 8'd9;
          5'd5:  row_val = 8'd5;
          5'd6:  row_val = 8'd19;
          5'd7:  row_val = 8'd5;
          5'd8:  row_val = 8'd9;
          5'd9:  row_val = 8'd5;
          5'd10: row_val = 8'd0;
          5'd11: row_val = 8'd39;
          5'd12: row_val = 8'd19;
          5'd13: row_val = 8'd5;
          5'd14: row_val = 8'd19;
          5'd15: row_val = 8'd5;
          5'd16: row_val = STOP_MARK;
          default: row_val = '0;
        endcase
      end
      4'd7: begin
        case (pos_i)
          5'd0: row_val = 8'd5;
          5'd1: row_val = 8'd5;
          5'd2: row_val = 8'd5;
          5'd3: row_val = 8'd100;
          5'd4: row_val = STOP_MARK;
          default: row_val = '0;
        endcase
      end
      4'd10: begin
        case (pos_i)
          5'd0: row_val = 8'd5;
          5'd1: row_val = 8'd5;
          5'd2: row_val = 8'd15;
          5'd3: row_val = 8'd5;
          5'd4: row_val = 8'd5;
          5'd5: row_val = 8'd5;
          5'd6: row_val = 8'd15;
          5'd7: row_val = 8'd30;
          5'd8: row_val = STOP_MARK;
          default: row_val = '0;
        endcase
      end
      4'd11: begin
        case (pos_i)
          5'd0: row_val = 8'd50;
          5'd1: row_val = 8'd50;
          5'd2: row_val = STOP_MARK;
          default: row_val = '0;
        endcase
      end
      default: row_val = STOP_MARK;
    endcase
  end

  // out of range rows or positions read as the stop mark
  always_comb begin
    if ((32'(pat_i) >= ROM_ROWS) || (32'(pos_i) >= ROW_LEN) ||
        (32'(pos_i) >= MAX_STEPS)) begin
      entry_o = STOP_MARK;
    end else begin
      entry_o = row_val;
    end
  end

endmodule

### rtl/bps_player.sv
module bps_player (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bps_pkg::cfg_wr_t cfg_wr_i,
  input  logic             fire_i,
  input  bps_pkg::in_t     item_i,
  output bps_pkg::out_t    result_o
);
  import bps_pkg::*;

  logic               enable_q, enable_d;
  logic [UNIT_W-1:0]  unit_q, unit_d;
  logic               active_q, active_d;
  logic [PAT_W-1:0]   cur_q, cur_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               phase_q, phase_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic               drive_q, drive_d;
  logic               done;
  logic [ENTRY_W-1:0] entry;
  logic               pat_ok;

  bps_rom u_rom (
    .pat_i   (cur_q),
    .pos_i   (pos_q),
    .entry_o (entry)
  );

  assign pat_ok = (32'(item_i.pattern) < NUM_PATTERNS) && (32'(item_i.pattern) < ROM_ROWS);

  always_comb begin
    enable_d = enable_q;
    unit_d   = unit_q;
    active_d = active_q;
    cur_d    = cur_q;
    pos_d    = pos_q;
    phase_d  = phase_q;
    rem_d    = rem_q;
    drive_d  = drive_q;
    done     = 1'b0;

    if (fire_i) begin
      case (mode_e'(item_i.mode))
        MODE_TICK: begin
          if (active_q) begin
            if (rem_q > REM_W'(1)) begin
              rem_d = rem_q - 1'b1;
            end else begin
              phase_d = ~phase_q;
              if (entry != '0) begin
                drive_d = ~phase_q;
              end
              if (entry == STOP_MARK) begin
                drive_d  = 1'b0;
                phase_d  = 1'b0;
                rem_d    = '0;
                pos_d    = '0;
                active_d = 1'b0;
                done     = 1'b1;
              end else begin
                rem_d = REM_W'(entry) * REM_W'(unit_q);
                pos_d = pos_q + 1'b1;
              end
            end
          end
        end
        MODE_PLAY: begin
          if (enable_q && pat_ok && (!active_q || (item_i.pattern < cur_q))) begin
            active_d = 1'b1;
            cur_d    = item_i.pattern;
            pos_d    = '0;
            rem_d    = '0;
          end
        end
        MODE_SILENCE: begin
          done     = active_q;
          drive_d  = 1'b0;
          phase_d  = 1'b0;
          rem_d    = '0;
          pos_d    = '0;
          active_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // register writes must arrive only while idle; the block does not enforce this
    if (cfg_wr_i.we) begin
      case (cfg_idx_e'(cfg_wr_i.idx))
        CFG_ENABLE: begin
          enable_d = cfg_wr_i.data[0];
          if (!cfg_wr_i.data[0]) begin
            drive_d  = 1'b0;
            phase_d  = 1'b0;
            rem_d    = '0;
            pos_d    = '0;
            active_d = 1'b0;
          end
        end
        CFG_UNIT_MS: unit_d = cfg_wr_i.data[UNIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign result_o.buzzer_on = drive_d;
  assign result_o.busy_res  = active_d;
  assign result_o.done_res  = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      unit_q   <= UNIT_MS_RESET;
      active_q <= 1'b0;
      cur_q    <= '0;
      pos_q    <= '0;
      phase_q  <= 1'b0;
      rem_q    <= '0;
      drive_q  <= 1'b0;
    end else begin
      enable_q <= enable_d;
      unit_q   <= unit_d;
      active_q <= active_d;
      cur_q    <= cur_d;
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      rem_q    <= rem_d;
      drive_q  <= drive_d;
    end
  end

endmodule

### rtl/beeper_pattern_sequencer_core.sv
// beeper pattern sequencer
// input channel (in_valid_i / in_ready_o / in_data_i) carries one item per
// transfer: a millisecond tick, a play request for a pattern, or a silence
// request. every item gives exactly one result on the output channel
// (out_valid_o / out_ready_i / out_data_o): buzzer level, busy flag and a
// done pulse.
// an accepted item lands in an input register; the player consumes it once
// the output slot is free or is being emptied, and its result is loaded into
// the output register, from which it is offered on the output channel.
// throughput is one item per cycle while the receiver keeps up: the player
// update is one countdown step plus one pattern rom lookup and one 4x8
// multiply for the reload.
// when the receiver stalls, the output register holds its result and the
// input register takes one more item; then in_ready_o drops until the
// output is taken.
// the user must write registers through cfg_we_i / cfg_idx_i / cfg_data_i
// only while the block is idle (unenforced). writing enable to zero silences
// the player at once. reset (rst_ni low) clears both pipeline registers,
// idles the player with the buzzer off, sets enable to one, unit_ms to ten.
module beeper_pattern_sequencer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bps_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bps_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bps_pkg::*;

  logic    in_valid_q;
  in_t     in_q;
  logic    out_valid_q;
  out_t    out_q;
  logic    advance;
  out_t    result;
  cfg_wr_t cfg_wr;

  // the player consumes the held item whenever the output slot is free
  // or is being emptied in this cycle
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_data_i;

  bps_player u_player (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_wr),
    .fire_i   (advance),
    .item_i   (in_q),
    .result_o (result)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/bps_checker.sv
module bps_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input bps_pkg::out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // the buzzer only sounds while a pattern plays; done ends it
  a_buzz_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.buzzer_on || out_data_o.done_res) |->
    (out_data_o.buzzer_on ? out_data_o.busy_res : !out_data_o.busy_res))
    else $error("buzzer or done inconsistent with busy");

  // a fresh result follows an earlier input transfer
  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without input transfer");

  // with the receiver ready the block never stalls its sender
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output ready");

endmodule

bind beeper_pattern_sequencer_core bps_checker u_bps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
